[rtl/core/tgarle_pkg.sv]
// Shared types and constants of the TGA run-length pixel decoder.
package tgarle_pkg;

   localparam int unsigned DIM_W = 16;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_SIZE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RUN_LENGTH_MODE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_AT_TOP = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RIGHT_TO_LEFT = 3'd5;

   localparam logic [1:0] PIX_SIZE_GREY = 2'd0;
   localparam logic [1:0] PIX_SIZE_BGR = 2'd1;
   localparam logic [1:0] PIX_SIZE_BGRA = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [1:0]       pixel_size;
      logic             run_length_mode;
      logic             origin_at_top;
      logic             right_to_left;
   } cfg_type;

   typedef struct packed {
      logic               clear;
      logic               has_pixel;
      logic [31:0]        pixel;
      logic [COUNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic busy;
      logic complete;
   } back_status_type;

endpackage

[rtl/core/tgarle_ifs.sv]
// Channel interfaces for the input byte stream and the pixel write results.
interface tgarle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tgarle_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;
   logic [15:0] row_a;
   logic [15:0] col_a;
   logic        has_second;
   logic [15:0] row_b;
   logic [15:0] col_b;
   logic        last_of_run;
   logic        image_done;

   modport source (output valid, output pixel_argb, output row_a, output col_a,
                   output has_second, output row_b, output col_b, output last_of_run,
                   output image_done, input ready);
   modport sink (input valid, input pixel_argb, input row_a, input col_a,
                 input has_second, input row_b, input col_b, input last_of_run,
                 input image_done, output ready);
endinterface

[rtl/core/tgarle_front.sv]
// Front end: packet header parsing and pixel byte assembly into pixel jobs.
module tgarle_front (
   input  logic                clock,
   input  logic                reset,
   input  tgarle_pkg::cfg_type cfg,
   tgarle_req_if.sink          req_chan,
   output tgarle_pkg::job_type job,
   output logic                job_valid,
   input  logic                job_ready
);
   import tgarle_pkg::*;

   logic               expect_ff, expect_in;
   logic [1:0]         bip_ff, bip_in;
   logic [23:0]        held_ff, held_in;
   logic               raw_ff, raw_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;

   logic               cur_expect;
   logic [1:0]         cur_bip;
   logic [23:0]        cur_held;
   logic               cur_raw;
   logic [COUNT_W-1:0] cur_rem;
   logic [2:0]         need;
   logic [7:0]         b;
   logic               accept;

   assign b = req_chan.data_byte;
   assign accept = req_chan.valid && job_ready;
   assign req_chan.ready = job_ready;

   always_comb begin
      unique case (cfg.pixel_size)
         PIX_SIZE_GREY: need = 3'd1;
         PIX_SIZE_BGR:  need = 3'd3;
         default:       need = 3'd4;
      endcase
   end

   always_comb begin
      if (req_chan.frame_start) begin
         cur_expect = 1'b1;
         cur_bip = 2'd0;
         cur_held = 24'd0;
         cur_raw = 1'b0;
         cur_rem = '0;
      end else begin
         cur_expect = expect_ff;
         cur_bip = bip_ff;
         cur_held = held_ff;
         cur_raw = raw_ff;
         cur_rem = rem_ff;
      end
   end

   always_comb begin
      expect_in = expect_ff;
      bip_in = bip_ff;
      held_in = held_ff;
      raw_in = raw_ff;
      rem_in = rem_ff;
      job = '0;
      job_valid = 1'b0;
      if (accept) begin
         expect_in = cur_expect;
         bip_in = cur_bip;
         held_in = cur_held;
         raw_in = cur_raw;
         rem_in = cur_rem;
         job.clear = req_chan.frame_start;
         job_valid = req_chan.frame_start;
         if (cfg.image_width != '0 && cfg.image_height != '0) begin
            job_valid = 1'b1;
            if (cfg.run_length_mode && cur_expect) begin
               raw_in = ~b[7];
               rem_in = {1'b0, b[6:0]} + 8'd1;
               expect_in = 1'b0;
            end else if ({1'b0, cur_bip} + 3'd1 < need) begin
               unique case (cur_bip)
                  2'd0:    held_in[7:0] = b;
                  2'd1:    held_in[15:8] = b;
                  2'd2:    held_in[23:16] = b;
                  default: held_in = cur_held;
               endcase
               bip_in = cur_bip + 2'd1;
            end else begin
               job.has_pixel = 1'b1;
               if (need == 3'd1) begin
                  job.pixel = {8'hFF, b, b, b};
               end else if (need == 3'd3) begin
                  job.pixel = {8'hFF, b, cur_held[15:0]};
               end else begin
                  job.pixel = {b, cur_held};
               end
               bip_in = 2'd0;
               held_in = 24'd0;
               if (!cfg.run_length_mode || cur_raw) begin
                  job.count = 8'd1;
                  if (cfg.run_length_mode) begin
                     if (cur_rem <= 8'd1) begin
                        rem_in = '0;
                        expect_in = 1'b1;
                     end else begin
                        rem_in = cur_rem - 8'd1;
                     end
                  end
               end else begin
                  job.count = (cur_rem == '0) ? 8'd1 : cur_rem;
                  rem_in = '0;
                  expect_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         bip_ff <= 2'd0;
         held_ff <= 24'd0;
         raw_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         expect_ff <= expect_in;
         bip_ff <= bip_in;
         held_ff <= held_in;
         raw_ff <= raw_in;
         rem_ff <= rem_in;
      end
   end

endmodule

[rtl/core/tgarle_queue.sv]
// Two-entry job queue between the front end and the write expander.
module tgarle_queue (
   input  logic                clock,
   input  logic                reset,
   input  tgarle_pkg::job_type in_job,
   input  logic                in_valid,
   output logic                in_ready,
   output tgarle_pkg::job_type out_job,
   output logic                out_valid,
   input  logic                out_ready
);
   import tgarle_pkg::*;

   job_type    head_ff, head_in;
   job_type    tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = head_ff;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      unique case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = in_job;
            end else begin
               tail_in = in_job;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = tail_ff;
            cnt_in = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = in_job;
            end else begin
               head_in = tail_ff;
               tail_in = in_job;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/core/tgarle_back.sv]
// Back end: stream position tracking and expansion of pixel jobs into write beats.
module tgarle_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tgarle_pkg::cfg_type         cfg,
   input  tgarle_pkg::job_type         job,
   input  logic                        job_valid,
   output logic                        job_ready,
   output tgarle_pkg::back_status_type status,
   tgarle_rsp_if.source                rsp_chan
);
   import tgarle_pkg::*;

   typedef struct packed {
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic             complete;
   } pos_type;

   function automatic pos_type advance(input logic [DIM_W-1:0] row,
                                       input logic [DIM_W-1:0] col,
                                       input logic [DIM_W-1:0] width,
                                       input logic [DIM_W-1:0] height);
      pos_type    p;
      logic [DIM_W:0] c;
      c = {1'b0, col} + {{DIM_W{1'b0}}, 1'b1};
      p.row = row;
      p.col = c[DIM_W-1:0];
      if (c >= {1'b0, width}) begin
         p.col = '0;
         p.row = row + {{(DIM_W-1){1'b0}}, 1'b1};
      end
      p.complete = (p.row >= height);
      return p;
   endfunction

   function automatic logic [DIM_W-1:0] dest_row(input logic [DIM_W-1:0] row,
                                                 input cfg_type c);
      return c.origin_at_top ? row : (c.image_height - {{(DIM_W-1){1'b0}}, 1'b1} - row);
   endfunction

   function automatic logic [DIM_W-1:0] dest_col(input logic [DIM_W-1:0] col,
                                                 input cfg_type c);
      return c.right_to_left ? (c.image_width - {{(DIM_W-1){1'b0}}, 1'b1} - col) : col;
   endfunction

   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic               complete_ff, complete_in;
   logic               busy_ff, busy_in;
   logic [31:0]        pix_ff, pix_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;

   logic               ovalid_ff, ovalid_in;
   logic [31:0]        opix_ff, opix_in;
   logic [DIM_W-1:0]   orow_a_ff, orow_a_in, ocol_a_ff, ocol_a_in;
   logic               osecond_ff, osecond_in;
   logic [DIM_W-1:0]   orow_b_ff, orow_b_in, ocol_b_ff, ocol_b_in;
   logic               olast_ff, olast_in;
   logic               odone_ff, odone_in;

   logic               pop, emit;
   pos_type            s1, s2, fin, start;
   logic [COUNT_W-1:0] rem1, rem_fin;
   logic               second;

   assign job_ready = !busy_ff;
   assign pop = job_valid && !busy_ff;
   assign emit = busy_ff && (!ovalid_ff || rsp_chan.ready);

   assign status.busy = busy_ff;
   assign status.complete = complete_ff;

   assign rsp_chan.valid = ovalid_ff;
   assign rsp_chan.pixel_argb = opix_ff;
   assign rsp_chan.row_a = orow_a_ff;
   assign rsp_chan.col_a = ocol_a_ff;
   assign rsp_chan.has_second = osecond_ff;
   assign rsp_chan.row_b = orow_b_ff;
   assign rsp_chan.col_b = ocol_b_ff;
   assign rsp_chan.last_of_run = olast_ff;
   assign rsp_chan.image_done = odone_ff;

   always_comb begin
      s1 = advance(row_ff, col_ff, cfg.image_width, cfg.image_height);
      s2 = advance(s1.row, s1.col, cfg.image_width, cfg.image_height);
      rem1 = rem_ff - 8'd1;
      second = (rem1 != '0) && !s1.complete;
      fin = second ? s2 : s1;
      rem_fin = second ? (rem1 - 8'd1) : rem1;
   end

   always_comb begin
      start.row = job.clear ? '0 : row_ff;
      start.col = job.clear ? '0 : col_ff;
      start.complete = job.clear ? 1'b0 : complete_ff;
      if (cfg.image_width != '0 && cfg.image_height != '0 &&
          start.row >= cfg.image_height) begin
         start.complete = 1'b1;
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      complete_in = complete_ff;
      busy_in = busy_ff;
      pix_in = pix_ff;
      rem_in = rem_ff;
      ovalid_in = ovalid_ff;
      opix_in = opix_ff;
      orow_a_in = orow_a_ff;
      ocol_a_in = ocol_a_ff;
      osecond_in = osecond_ff;
      orow_b_in = orow_b_ff;
      ocol_b_in = ocol_b_ff;
      olast_in = olast_ff;
      odone_in = odone_ff;
      if (pop) begin
         row_in = start.row;
         col_in = start.col;
         complete_in = start.complete;
         if (job.has_pixel && !start.complete) begin
            busy_in = 1'b1;
            pix_in = job.pixel;
            rem_in = job.count;
         end
      end
      if (emit) begin
         ovalid_in = 1'b1;
         opix_in = pix_ff;
         orow_a_in = dest_row(row_ff, cfg);
         ocol_a_in = dest_col(col_ff, cfg);
         osecond_in = second;
         orow_b_in = second ? dest_row(s1.row, cfg) : '0;
         ocol_b_in = second ? dest_col(s1.col, cfg) : '0;
         olast_in = (rem_fin == '0) || fin.complete;
         odone_in = fin.complete;
         row_in = fin.row;
         col_in = fin.col;
         complete_in = fin.complete;
         rem_in = rem_fin;
         busy_in = !((rem_fin == '0) || fin.complete);
      end else if (rsp_chan.ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      rem_ff <= rem_in;
      opix_ff <= opix_in;
      orow_a_ff <= orow_a_in;
      ocol_a_ff <= ocol_a_in;
      osecond_ff <= osecond_in;
      orow_b_ff <= orow_b_in;
      ocol_b_ff <= ocol_b_in;
      olast_ff <= olast_in;
      odone_ff <= odone_in;
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         complete_ff <= 1'b0;
         busy_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         complete_ff <= complete_in;
         busy_ff <= busy_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

[rtl/core/tga_rle_pixel_decoder.sv]
// Top level of the TGA run-length pixel decoder: registers, front end, queue and expander.
// A byte is taken each cycle while the two-entry job queue has room.
// The beat that completes a pixel goes through the job queue and the expander's job
// registers before its first result is registered. The expander takes a new job only
// once every result of the last is emitted; a run of N pixels gives ceil(N/2) results.
// Synchronous reset loads the register defaults and clears all frame and handshake state.
module tga_rle_pixel_decoder (
   input  logic                              clock,
   input  logic                              reset,
   tgarle_req_if.sink                        req_chan,
   tgarle_rsp_if.source                      rsp_chan,
   input  logic                              csr_write_en,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tgarle_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   job_type         front_job, queue_job;
   logic            front_valid, front_ready;
   logic            queue_valid, queue_ready;
   back_status_type back_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:     cfg_in.image_width = csr_write_data;
            REG_IMAGE_HEIGHT:    cfg_in.image_height = csr_write_data;
            REG_PIXEL_SIZE:      cfg_in.pixel_size = csr_write_data[1:0];
            REG_RUN_LENGTH_MODE: cfg_in.run_length_mode = csr_write_data[0];
            REG_ORIGIN_AT_TOP:   cfg_in.origin_at_top = csr_write_data[0];
            REG_RIGHT_TO_LEFT:   cfg_in.right_to_left = csr_write_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width <= 16'd1;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.pixel_size <= PIX_SIZE_BGRA;
         cfg_ff.run_length_mode <= 1'b0;
         cfg_ff.origin_at_top <= 1'b0;
         cfg_ff.right_to_left <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgarle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   tgarle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_job    (front_job),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_job   (queue_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   tgarle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (queue_job),
      .job_valid (queue_valid),
      .job_ready (queue_ready),
      .status    (back_status),
      .rsp_chan  (rsp_chan)
   );

   // A beat that finishes the image always closes the writes of its job.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.image_done |-> rsp_chan.last_of_run)
      else $error("image_done beat without last_of_run");

   // A beat carrying one write leaves the second position at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.has_second |-> rsp_chan.row_b == '0 && rsp_chan.col_b == '0)
      else $error("second position set on a single-write beat");

   // An idle expander with an empty output stage cannot raise a beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !back_status.busy && !rsp_chan.valid |=> !rsp_chan.valid)
      else $error("result beat appeared without an active job");

   // While the image is finished the expander takes on no further writes.
   assert property (@(posedge clock) disable iff (reset)
      back_status.complete |-> !back_status.busy)
      else $error("expander busy after image completion");

endmodule
